@@ rtl/core/mouse_look_direction_macros.svh @@
// Assertion macros for the mouse look direction block
`ifndef MOUSE_LOOK_DIRECTION_MACROS_SVH
`define MOUSE_LOOK_DIRECTION_MACROS_SVH

// same-cycle implication
`define MLD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mouse_look_direction check failed");

// next-cycle implication
`define MLD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mouse_look_direction check failed");

`endif

@@ rtl/core/mld_pkg.sv @@
// Package: types, constants and helpers of the mouse look direction block
`timescale 1ns / 1ps
`default_nettype none
package mld_pkg;

    localparam int CW = 33;
    localparam int DIV_BITS = 38;
    localparam logic [15:0] SENS_RESET = 16'd3277;
    localparam logic [13:0] LIMIT_RESET = 14'd11392;
    localparam logic [15:0] YAW_RESET = 16'd34560;
    localparam logic signed [CW-1:0] CORDIC_X0 = 33'sh026DD3B6A;

    localparam logic [0:0] CFG_SENS = 1'b0;
    localparam logic [0:0] CFG_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE, S_STEP, S_UPD, S_WRAP, S_CORD, S_MUL, S_OUT
    } top_state_t;

    typedef enum logic [1:0] {
        CS_IDLE, CS_DIV, CS_ROT
    } cord_state_t;

    typedef struct packed {
        logic                 done;
        logic signed [CW-1:0] cos_v;
        logic signed [CW-1:0] sin_v;
    } cord_res_t;

    function automatic logic [31:0] atan_bam(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    function automatic logic signed [15:0] sat_unit(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sd16384) begin
            r = 16'sd16384;
        end else if (v < -20'sd16384) begin
            r = -16'sd16384;
        end else begin
            r = 16'(v);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/mld_cordic.sv @@
// Bit-serial angle conversion and iterative rotation-mode CORDIC
`timescale 1ns / 1ps
`default_nettype none
module mld_cordic #(
    parameter int STEPS = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [15:0]       angle,
    output mld_pkg::cord_res_t     res
);
    import mld_pkg::*;

    cord_state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [5:0] rem_reg, rem_next;
    logic [DIV_BITS-1:0] dvd_reg, dvd_next;
    logic [31:0] q_reg, q_next;
    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic flip_reg, flip_next, done_reg, done_next;

    logic [6:0] trial;
    logic ge;
    logic [31:0] qf;
    logic signed [CW-1:0] z0, xs, ys, at;
    logic [4:0] idx;

    assign trial = {rem_reg, dvd_reg[DIV_BITS-1]};
    assign ge = trial >= 7'd45;
    assign qf = {q_reg[30:0], ge};
    assign z0 = $signed({qf[31], qf});
    assign idx = cnt_reg[4:0];
    assign xs = x_reg >>> idx;
    assign ys = y_reg >>> idx;
    assign at = $signed({1'b0, atan_bam(idx)});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
            done_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        q_reg <= q_next;
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        flip_reg <= flip_next;
    end

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        q_next = q_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        flip_next = flip_reg;
        done_next = 1'b0;
        case (state_reg)
            CS_IDLE: begin
                if (start) begin
                    dvd_next = {angle, 22'd22};
                    rem_next = '0;
                    q_next = '0;
                    cnt_next = '0;
                    state_next = CS_DIV;
                end
            end
            CS_DIV: begin
                rem_next = ge ? 6'(trial - 7'd45) : trial[5:0];
                q_next = qf;
                dvd_next = {dvd_reg[DIV_BITS-2:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_BITS - 1)) begin
                    cnt_next = '0;
                    x_next = CORDIC_X0;
                    y_next = '0;
                    if (z0 > 33'sh040000000) begin
                        z_next = z0 - 33'sh080000000;
                        flip_next = 1'b1;
                    end else if (z0 < -33'sh040000000) begin
                        z_next = z0 + 33'sh080000000;
                        flip_next = 1'b1;
                    end else begin
                        z_next = z0;
                        flip_next = 1'b0;
                    end
                    state_next = CS_ROT;
                end
            end
            CS_ROT: begin
                if (z_reg >= 0) begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - at;
                end else begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + at;
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(STEPS - 1)) begin
                    done_next = 1'b1;
                    state_next = CS_IDLE;
                end
            end
            default: state_next = CS_IDLE;
        endcase
    end

    assign res.done = done_reg;
    assign res.cos_v = flip_reg ? -x_reg : x_reg;
    assign res.sin_v = flip_reg ? -y_reg : y_reg;

endmodule
`default_nettype wire

@@ rtl/core/mouse_look_direction.sv @@
// Top level: mouse look camera direction from cursor positions
//
// Usage:
//   s_ channel carries one cursor sample per item (x and y, Q16.4 pixels).
//   m_ channel returns one item per sample: direction x/y/z in Q1.14 and the
//   updated yaw and pitch in 1/128 degree.
//   cfg_wr_en/cfg_index/cfg_wdata write sensitivity (0) and pitch limit (1);
//   write only while no item is in flight.
// Timing:
//   One item at a time. From the accepting edge to m_tvalid an item passes
//   scaling and update, bit-serial yaw reduction, bit-serial angle
//   conversion plus CORDIC_STEPS rotations, a handoff, a bit-serial
//   product and the load of the output register.
//   No new sample is taken until the last one has left the output stage;
//   the serial units take most of that time.
// Reset:
//   Synchronous, active low; sensitivity 0.05, limit 89 degrees, yaw
//   270 degrees, pitch 0, the next sample is treated as the first.
// Stall:
//   A finished item waits in the output register while m_tready is low; the
//   block then holds its next result until the register frees.
`timescale 1ns / 1ps
`default_nettype none
module mouse_look_direction #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // cursor_x, cursor_y
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // dir_x, dir_y, dir_z, yaw_now, pitch_now, pad
    input  wire logic        cfg_wr_en,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);
    import mld_pkg::*;

    localparam int PW = 2 * CW;

    top_state_t state_reg, state_next;

    logic [15:0] sens_reg;
    logic [13:0] lim_reg;
    logic first_reg;
    logic signed [19:0] prev_x_reg, prev_y_reg;
    logic signed [20:0] dx_reg, dy_reg;
    logic signed [24:0] stepx_reg, stepy_reg;
    logic [15:0] yaw_reg;
    logic signed [14:0] pitch_reg;
    logic [24:0] wrap_reg, modk_reg;
    logic [5:0] cnt_reg;
    logic signed [PW-1:0] acc_x_reg, acc_z_reg, mc_x_reg, mc_z_reg;
    logic [CW-1:0] mp_reg;
    logic out_valid_reg;
    logic [79:0] out_reg;

    logic signed [19:0] cx, cy;
    logic signed [37:0] prodx, prody;
    logic signed [25:0] ysum, psum, lim26;
    logic [24:0] wrap_new;
    logic wrap_last, cord_start, s_acc, out_free;
    logic [15:0] yaw_u, pitch_u;
    logic signed [16:0] pitch_w;
    cord_res_t pres, yres;
    logic signed [PW-1:0] add_x, add_z;
    logic mbit, mlast;
    logic signed [PW-1:0] rnd_x, rnd_z;
    logic signed [CW-1:0] rnd_y;
    logic signed [15:0] dir_x, dir_y, dir_z;

    assign cx = $signed(s_tdata[19:0]);
    assign cy = $signed(s_tdata[39:20]);
    assign s_tready = (state_reg == S_IDLE);
    assign s_acc = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign prodx = dx_reg * $signed({1'b0, sens_reg});
    assign prody = dy_reg * $signed({1'b0, sens_reg});
    assign ysum = $signed({10'd0, yaw_reg}) + 26'(stepx_reg) + 26'sd11796480;
    assign psum = 26'(pitch_reg) + 26'(stepy_reg);
    assign lim26 = $signed({12'd0, lim_reg});

    assign wrap_new = (wrap_reg >= modk_reg) ? wrap_reg - modk_reg : wrap_reg;
    assign wrap_last = (state_reg == S_WRAP) && (cnt_reg == 6'd8);
    assign cord_start = wrap_last;
    assign yaw_u = wrap_new[15:0];
    assign pitch_w = 17'(pitch_reg) + 17'sd46080;
    assign pitch_u = pitch_reg[14] ? pitch_w[15:0] : 16'(pitch_reg);

    mld_cordic #(.STEPS(CORDIC_STEPS)) u_cord_p (
        .aclk(aclk), .aresetn(aresetn), .start(cord_start), .angle(pitch_u), .res(pres)
    );
    mld_cordic #(.STEPS(CORDIC_STEPS)) u_cord_y (
        .aclk(aclk), .aresetn(aresetn), .start(cord_start), .angle(yaw_u), .res(yres)
    );

    // serial signed multiply, sign bit of the multiplier weighs negative
    assign mbit = mp_reg[0];
    assign mlast = (cnt_reg == 6'(CW - 1));
    assign add_x = mbit ? (mlast ? -mc_x_reg : mc_x_reg) : '0;
    assign add_z = mbit ? (mlast ? -mc_z_reg : mc_z_reg) : '0;

    assign rnd_x = (acc_x_reg + (PW'(1) <<< 45)) >>> 46;
    assign rnd_z = (acc_z_reg + (PW'(1) <<< 45)) >>> 46;
    assign rnd_y = (pres.sin_v + 33'sd32768) >>> 16;
    assign dir_x = sat_unit(20'(rnd_x));
    assign dir_z = sat_unit(20'(rnd_z));
    assign dir_y = sat_unit(20'(rnd_y));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_acc) state_next = S_STEP;
            S_STEP: state_next = S_UPD;
            S_UPD:  state_next = S_WRAP;
            S_WRAP: if (wrap_last) state_next = S_CORD;
            S_CORD: if (pres.done) state_next = S_MUL;
            S_MUL:  if (mlast) state_next = S_OUT;
            S_OUT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sens_reg <= SENS_RESET;
            lim_reg <= LIMIT_RESET;
            first_reg <= 1'b1;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            yaw_reg <= YAW_RESET;
            pitch_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SENS:  sens_reg <= cfg_wdata;
                    CFG_LIMIT: lim_reg <= cfg_wdata[13:0];
                    default: ;
                endcase
            end
            if (s_acc) begin
                first_reg <= 1'b0;
                prev_x_reg <= cx;
                prev_y_reg <= cy;
            end
            if (state_reg == S_UPD) begin
                if (psum > lim26) begin
                    pitch_reg <= 15'(lim26);
                end else if (psum < -lim26) begin
                    pitch_reg <= 15'(-lim26);
                end else begin
                    pitch_reg <= 15'(psum);
                end
            end
            if (wrap_last) yaw_reg <= wrap_new[15:0];
            if (state_reg == S_OUT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (first_reg) begin
                    dx_reg <= '0;
                    dy_reg <= '0;
                end else begin
                    dx_reg <= 21'(cx) - 21'(prev_x_reg);
                    dy_reg <= 21'(prev_y_reg) - 21'(cy);
                end
            end
            S_STEP: begin
                stepx_reg <= 25'((prodx + 38'sd4096) >>> 13);
                stepy_reg <= 25'((prody + 38'sd4096) >>> 13);
            end
            S_UPD: begin
                wrap_reg <= 25'(ysum);
                modk_reg <= 25'd11796480;
                cnt_reg <= '0;
            end
            S_WRAP: begin
                wrap_reg <= wrap_new;
                modk_reg <= {1'b0, modk_reg[24:1]};
                cnt_reg <= cnt_reg + 6'd1;
            end
            S_CORD: begin
                mp_reg <= pres.cos_v;
                mc_x_reg <= PW'(yres.cos_v);
                mc_z_reg <= PW'(yres.sin_v);
                acc_x_reg <= '0;
                acc_z_reg <= '0;
                cnt_reg <= '0;
            end
            S_MUL: begin
                acc_x_reg <= acc_x_reg + add_x;
                acc_z_reg <= acc_z_reg + add_z;
                mc_x_reg <= mc_x_reg <<< 1;
                mc_z_reg <= mc_z_reg <<< 1;
                mp_reg <= {1'b0, mp_reg[CW-1:1]};
                cnt_reg <= cnt_reg + 6'd1;
            end
            S_OUT: begin
                if (out_free) begin
                    out_reg <= {1'b0, pitch_reg, yaw_reg, dir_z, dir_y, dir_x};
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_reg;

endmodule
`default_nettype wire

@@ rtl/core/mld_checker.sv @@
// Port-level checker for the mouse look direction block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "mouse_look_direction_macros.svh"
module mld_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [79:0] m_tdata
);
    logic in_take;
    logic yaw_ok, diry_ok;

    assign in_take = s_tvalid && s_tready;
    assign yaw_ok = m_tdata[63:48] < 16'd46080;
    assign diry_ok = ($signed(m_tdata[31:16]) <= 16'sd16384) &&
                     ($signed(m_tdata[31:16]) >= -16'sd16384);

    `MLD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `MLD_ASSERT_NEXT(a_busy_after_take, in_take, !s_tready)
    `MLD_ASSERT_NOW(a_yaw_range, m_tvalid, yaw_ok)
    `MLD_ASSERT_NOW(a_diry_range, m_tvalid, diry_ok)

endmodule

bind mouse_look_direction mld_checker u_mld_checker (.*);
`default_nettype wire

@@ test/mouse_look_direction_test.sv @@
// Testbench for mouse_look_direction: directed table, then random cursor samples
`timescale 1ns / 1ps
`default_nettype none
module mouse_look_direction_test;
    import mld_pkg::*;

    localparam int STEPS = 16;
    localparam int TURN = 46080;
    localparam longint LIMIT_CYCLES = 2000000;

    typedef struct packed {
        logic signed [14:0] pitch_now;
        logic [15:0]        yaw_now;
        logic signed [15:0] dir_z;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_x;
    } look_t;

    typedef struct {
        logic signed [19:0] cx;
        logic signed [19:0] cy;
        bit                 known;
        look_t              want;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [39:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic cfg_wr_en = 1'b0;
    logic [0:0] cfg_index = CFG_SENS;
    logic [15:0] cfg_wdata = '0;

    mouse_look_direction #(.CORDIC_STEPS(STEPS)) dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor state
    longint sens_q, limit_q, yaw_q, pitch_q;
    logic signed [19:0] last_x, last_y;
    bit fresh;

    look_t looks_due[$];
    row_t table_q[$];
    int errors = 0;
    longint cycles = 0;
    bit done_flag = 0;
    int stall_mode = 0;

    function automatic longint fl_shift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint wrap(longint a);
        longint r = a % TURN;
        return r < 0 ? r + TURN : r;
    endfunction

    function automatic longint to_binang(longint a);
        logic [63:0] u;
        longint b;
        u = wrap(a);
        b = longint'(((u << 32) + TURN / 2) / TURN);
        if (b >= 64'sh80000000) b -= 64'sh100000000;
        return b;
    endfunction

    task automatic rotate(input longint a, output longint c, output longint s);
        longint z, x, y, t;
        bit flip;
        z = to_binang(a);
        x = 64'h26DD3B6A;
        y = 0;
        flip = 0;
        if (z > 64'sh40000000) begin
            z -= 64'sh80000000; flip = 1;
        end else if (z < -64'sh40000000) begin
            z += 64'sh80000000; flip = 1;
        end
        for (int i = 0; i < STEPS && i < 24; i++) begin
            if (z >= 0) begin
                t = x - fl_shift(y, i); y = y + fl_shift(x, i); z -= longint'(atan_bam(5'(i)));
            end else begin
                t = x + fl_shift(y, i); y = y - fl_shift(x, i); z += longint'(atan_bam(5'(i)));
            end
            x = t;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint clamp_unit(longint v);
        return v > 16384 ? 16384 : (v < -16384 ? -16384 : v);
    endfunction

    task automatic predict_look(input logic signed [19:0] cx, input logic signed [19:0] cy,
                                output look_t r);
        longint dx, dy, cp, sp, cyw, syw;
        dx = 0; dy = 0;
        if (!fresh) begin
            dx = longint'(cx) - longint'(last_x);
            dy = longint'(last_y) - longint'(cy);
        end
        fresh = 0;
        last_x = cx; last_y = cy;
        yaw_q = wrap(yaw_q + fl_shift(dx * sens_q + 4096, 13));
        pitch_q += fl_shift(dy * sens_q + 4096, 13);
        if (pitch_q > limit_q) pitch_q = limit_q;
        if (pitch_q < -limit_q) pitch_q = -limit_q;
        rotate(pitch_q, cp, sp);
        rotate(yaw_q, cyw, syw);
        r.dir_x = 16'(clamp_unit(fl_shift(cp * cyw + (64'sd1 <<< 45), 46)));
        r.dir_y = 16'(clamp_unit(fl_shift(sp + (64'sd1 <<< 15), 16)));
        r.dir_z = 16'(clamp_unit(fl_shift(cp * syw + (64'sd1 <<< 45), 46)));
        r.yaw_now = 16'(yaw_q);
        r.pitch_now = 15'(pitch_q);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_SENS) sens_q = val;
        else limit_q = val & 16'h3FFF;
    endtask

    task automatic send_item(input logic signed [19:0] cx, input logic signed [19:0] cy,
                             input bit known, input look_t want);
        look_t p;
        predict_look(cx, cy, p);
        if (known && p != want) begin
            errors++;
            if (errors <= 10) $display("table row disagrees: %h vs %h", want, p);
        end
        looks_due.push_back(p);
        s_tvalid <= 1'b1;
        s_tdata <= {cy, cx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drive_burst(input int n, input bit big);
        int burst;
        logic signed [19:0] bx, by;
        look_t none;
        none = '0;
        burst = 0;
        bx = last_x; by = last_y;
        for (int k = 0; k < n; k++) begin
            if (burst == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(0, 40)) @(posedge aclk);
                burst = $urandom_range(1, 12);
            end
            burst--;
            if (big || $urandom_range(0, 9) == 0) begin
                bx = 20'($urandom); by = 20'($urandom);
            end else begin
                bx = bx + 20'($signed($urandom_range(0, 800)) - 400);
                by = by + 20'($signed($urandom_range(0, 800)) - 400);
            end
            send_item(bx, by, 0, none);
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic drain;
        while (looks_due.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    // result checker
    always @(posedge aclk) begin
        look_t got, w;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[78:0];
            if (looks_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected item %h", got);
            end else begin
                w = looks_due.pop_front();
                if (got != w) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp x%0d y%0d z%0d yaw%0d p%0d got x%0d y%0d z%0d yaw%0d p%0d",
                                 w.dir_x, w.dir_y, w.dir_z, w.yaw_now, w.pitch_now,
                                 got.dir_x, got.dir_y, got.dir_z, got.yaw_now, got.pitch_now);
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        cycles++;
        if (cycles % 3000 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ((cycles % 97) > 60);
            default: m_tready <= ($urandom_range(0, 1) != 0);
        endcase
        if (cycles > LIMIT_CYCLES && !done_flag) begin
            $display("** mouse_look_direction: FAILED **");
            $finish;
        end
    end

    initial begin
        row_t r;
        look_t z;
        z = '0;
        sens_q = 3277; limit_q = 11392; yaw_q = 34560; pitch_q = 0;
        fresh = 1; last_x = 0; last_y = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // first sample: yaw 270 degrees, pitch 0, direction (0, 0, -1)
        r = '{20'sd100, 20'sd200, 1, '{15'sd0, 16'd34560, -16'sd16384, 16'sd0, 16'sd0}};
        table_q.push_back(r);
        r = '{20'sd100, 20'sd200, 0, z}; table_q.push_back(r);
        r = '{20'sd524287, -20'sd524288, 0, z}; table_q.push_back(r);
        r = '{-20'sd524288, 20'sd524287, 0, z}; table_q.push_back(r);
        r = '{-20'sd524288, -20'sd524288, 0, z}; table_q.push_back(r);
        r = '{20'sd524287, 20'sd524287, 0, z}; table_q.push_back(r);
        r = '{20'sd0, 20'sd0, 0, z}; table_q.push_back(r);
        r = '{20'sd16, -20'sd16, 0, z}; table_q.push_back(r);
        r = '{-20'sd1, 20'sd1, 0, z}; table_q.push_back(r);
        foreach (table_q[i]) send_item(table_q[i].cx, table_q[i].cy, table_q[i].known,
                                       table_q[i].want);
        s_tvalid <= 1'b0;
        drain();

        // max sensitivity, pitch limit beyond 90 degrees, then lowered
        write_reg(CFG_SENS, 16'hFFFF);
        write_reg(CFG_LIMIT, 16'h3FFF);
        drive_burst(20, 1);
        drain();
        write_reg(CFG_LIMIT, 16'd0);
        drive_burst(10, 1);
        drain();
        write_reg(CFG_SENS, 16'd0);
        write_reg(CFG_LIMIT, 16'd11519);
        drive_burst(10, 1);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_SENS, ph == 0 ? 16'd3277 : 16'($urandom));
            write_reg(CFG_LIMIT, ph == 0 ? 16'd11392 : 16'($urandom_range(0, 16383)));
            drive_burst(150, ph == 5);
            drain();
        end

        done_flag = 1;
        if (errors == 0) begin
            $display("** mouse_look_direction: PASSED **");
        end else begin
            $display("** mouse_look_direction: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+rtl/core
rtl/core/mld_pkg.sv
rtl/core/mld_cordic.sv
rtl/core/mouse_look_direction.sv
rtl/core/mld_checker.sv
test/mouse_look_direction_test.sv
